// ===== hdl/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg
// Types, constants and the byte-wide CRC-32C step for the frame scanner.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam logic [31:0] CRC_POLY       = 32'h82F6_3B78;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam int unsigned MAGIC_BYTES    = 4;
  localparam int unsigned HEADER_BYTES   = 8;
  localparam int unsigned FRAME_OVERHEAD = 12;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_length;
    logic [31:0] crc_received;
    logic [31:0] crc_computed;
  } out_item_t;

  // reflected crc-32c, one byte folded in lsb first
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== hdl/cfs_scan_core.sv =====
// ----------------------------------------------------------------------------
// cfs_scan_core
// Per-byte frame state (count, header, running crc, wire crc) and the
// end-of-buffer status evaluation.
// ----------------------------------------------------------------------------
module cfs_scan_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  cfs_pkg::in_item_t  item,
  input  logic [31:0]        frame_magic,
  output cfs_pkg::out_item_t result
);
  import cfs_pkg::*;

  // compare width covers the counter and a length plus overhead
  localparam int EW = ((COUNT_WIDTH > 33) ? COUNT_WIDTH : 33) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] crc_running, crc_running_next;
  logic [31:0] wire_crc_shift, wire_crc_shift_next;

  logic [EW-1:0] idx_e, len_e, total_e, plen_e, need_e;
  logic          in_payload, in_wire, complete;
  logic [31:0]   plen, wire_val, calc_val;

  assign idx_e      = EW'(byte_count);
  assign len_e      = EW'(length_shift);
  assign in_payload = idx_e < (len_e + EW'(HEADER_BYTES));
  assign in_wire    = idx_e < (len_e + EW'(FRAME_OVERHEAD));

  always_comb begin
    byte_count_next     = byte_count;
    magic_shift_next    = magic_shift;
    length_shift_next   = length_shift;
    crc_running_next    = crc_running;
    wire_crc_shift_next = wire_crc_shift;
    // a saturated counter freezes the whole frame state
    if (byte_count != CNT_MAX) begin
      priority if (idx_e < EW'(MAGIC_BYTES)) begin
        magic_shift_next = {magic_shift[23:0], item.data_byte};
      end else if (idx_e < EW'(HEADER_BYTES)) begin
        length_shift_next = {length_shift[23:0], item.data_byte};
      end else if (in_payload) begin
        crc_running_next = crc32c_byte(crc_running, item.data_byte);
      end else if (in_wire) begin
        wire_crc_shift_next = {wire_crc_shift[23:0], item.data_byte};
      end else begin
        // bytes after the crc are ignored
      end
      byte_count_next = byte_count + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_count     <= '0;
      magic_shift    <= '0;
      length_shift   <= '0;
      crc_running    <= ALL_ONES;
      wire_crc_shift <= '0;
    end else if (step) begin
      byte_count     <= byte_count_next;
      magic_shift    <= magic_shift_next;
      length_shift   <= length_shift_next;
      crc_running    <= crc_running_next;
      wire_crc_shift <= wire_crc_shift_next;
    end
  end

  // status as seen once the final byte is folded in
  assign total_e  = EW'(byte_count_next);
  assign plen     = (total_e >= EW'(HEADER_BYTES)) ? length_shift_next : 32'd0;
  assign plen_e   = EW'(plen);
  assign need_e   = plen_e + EW'(FRAME_OVERHEAD);
  assign complete = (total_e >= EW'(FRAME_OVERHEAD)) && (need_e <= total_e);
  assign wire_val = complete ? wire_crc_shift_next : 32'd0;
  assign calc_val = complete ? (crc_running_next ^ ALL_ONES) : 32'd0;

  always_comb begin
    result.payload_length = plen;
    result.crc_received   = wire_val;
    result.crc_computed   = calc_val;
    priority if (total_e < EW'(FRAME_OVERHEAD)) begin
      result.status = STATUS_TRUNCATED;
    end else if (magic_shift_next != frame_magic) begin
      result.status = STATUS_BAD_MAGIC;
    end else if (need_e > total_e) begin
      result.status = STATUS_TRUNCATED;
    end else if (wire_val != calc_val) begin
      result.status = STATUS_CRC_ERR;
    end else begin
      result.status = STATUS_OK;
    end
  end

endmodule

// ===== hdl/crc_checked_frame_scanner_top.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_scanner_top
// Byte-stream frame scanner: magic, length, payload crc-32c check.
// ----------------------------------------------------------------------------
// the result is registered: a last byte passes the input register, then loads the result register
// throughput: one byte per cycle while nothing stalls, set by the byte-wide crc step in the core
// the input register advances while the result register waits, except a
// last byte, which waits for the result register to free up
// synchronous reset clears handshake state, frame state and frame_magic
module crc_checked_frame_scanner_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  cfs_pkg::in_item_t  item_data,
  output logic               result_valid,
  input  logic               result_stall,
  output cfs_pkg::out_item_t result_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import cfs_pkg::*;

  logic        hold_valid;
  in_item_t    hold;
  logic        advance;
  logic        out_free;
  logic [31:0] frame_magic;
  out_item_t   core_result;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign advance    = hold_valid && (!hold.last_byte || out_free);
  assign item_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frame_magic <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold <= item_data;
    end
  end

  cfs_scan_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (hold),
    .frame_magic(frame_magic),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && hold.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // payload register loads only when a frame ends
  always_ff @(posedge clk) begin
    if (advance && hold.last_byte) begin
      result_data <= core_result;
    end
  end

endmodule
